[design/texture_unit_lru_binder_unit_macros.svh]
// Assertion macros shared by the texture unit binder RTL.
`ifndef TEXTURE_UNIT_LRU_BINDER_UNIT_MACROS_SVH
`define TEXTURE_UNIT_LRU_BINDER_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TULRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define TULRU_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

[design/tulru_pkg.sv]
// Package with types, widths and codes of the texture unit binder.
`default_nettype none
package tulru_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int ID_W           = 32;
  localparam int STAMP_W        = 32;
  localparam int SLOT_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int OP_W           = 2;
  localparam int OUT_TDATA_W    = 8;
  localparam int ENTRY_W        = ID_W + STAMP_W;

  typedef enum logic [OP_W-1:0] {
    OP_BIND       = 2'd0,
    OP_ADVANCE    = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT  = 2'd0,
    ST_LOAD = 2'd1,
    ST_FULL = 2'd2,
    ST_DONE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_e;

endpackage
`default_nettype wire

[design/tulru_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tulru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered: data appears in the cycle after the read is enabled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[design/texture_unit_lru_binder_unit.sv]
// Texture slot binder with least-recently-used replacement by frame stamp.
//
// Input channel (s_axis): tuser carries the opcode (bind, advance frame,
// invalidate), tdata the texture id. Output channel (m_axis): tdata carries
// the slot number in its low four bits, tuser the status code.
// Every input item gives exactly one result item.
// Slot ids and stamps sit in one RAM of SLOT_COUNT entries. A bind reads
// slots 1 to SLOT_COUNT-1 one per cycle through the single read port,
// stopping early on an id match, and then registers its result; advance
// frame and invalidate register their result on acceptance. The block is
// ready again once the registered result has moved into the output
// register. One item is worked on at a time; the next item is taken once
// the block is back in idle, which needs no space on the output side: a
// finished result waits in the output register while the next item is
// accepted, and the block holds its next result until the receiver takes
// the previous one.
// Reset clears the per-slot valid bits (an invalid slot reads as id zero,
// stamp zero), sets the frame counter to one and empties the output.
`default_nettype none
module texture_unit_lru_binder_unit
  import tulru_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [ID_W-1:0]        s_axis_tdata,   // [31:0] texture_id
  input  wire logic [OP_W-1:0]        s_axis_tuser,   // [1:0] opcode
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] slot, [7:4] zero
  output logic      [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
  localparam logic [STAMP_W-1:0] FRAME_MAX = '1;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [STAMP_W-1:0]    oldest_q, oldest_d;
  logic [IDX_W-1:0]      victim_q, victim_d;
  logic [STAMP_W-1:0]    frame_q, frame_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic                  rd_valid_q;
  logic [IDX_W-1:0]      res_idx_q, res_idx_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_idx_q, out_idx_d;
  status_e               out_status_q, out_status_d;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]    rd_data;

  logic [ID_W-1:0]       slot_id;
  logic [STAMP_W-1:0]    slot_stamp;
  logic [STAMP_W-1:0]    oldest_n;
  logic [IDX_W-1:0]      victim_n;
  logic                  in_fire;
  op_e                   in_op;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  // Slot table: texture id in the low half, frame stamp in the high half.
  tulru_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_op   = op_e'(s_axis_tuser);

  // A slot never written since reset or invalidate reads as all zero.
  assign slot_id    = rd_valid_q ? rd_data[ID_W-1:0] : '0;
  assign slot_stamp = rd_valid_q ? rd_data[ENTRY_W-1:ID_W] : '0;

  // Running oldest stamp including the slot now being compared.
  always_comb begin
    if (slot_stamp < oldest_q) begin
      oldest_n = slot_stamp;
      victim_n = cmp_idx_q;
    end else begin
      oldest_n = oldest_q;
      victim_n = victim_q;
    end
  end

  // Next state, RAM access and result capture.
  always_comb begin
    state_d      = state_q;
    cmp_idx_d    = cmp_idx_q;
    id_d         = id_q;
    oldest_d     = oldest_q;
    victim_d     = victim_q;
    frame_d      = frame_q;
    valid_d      = valid_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    wr_en        = 1'b0;
    wr_addr      = cmp_idx_q;
    wr_data      = {frame_q, id_q};
    rd_en        = 1'b0;
    rd_addr      = FIRST_IDX;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_idx_d    = '0;
          res_status_d = ST_DONE;
          state_d      = S_RESP;
          unique case (in_op)
            OP_BIND: begin
              id_d      = s_axis_tdata;
              oldest_d  = frame_q;
              victim_d  = '0;
              cmp_idx_d = FIRST_IDX;
              rd_en     = 1'b1;
              rd_addr   = FIRST_IDX;
              state_d   = S_SCAN;
            end
            OP_ADVANCE: begin
              if (frame_q != FRAME_MAX) begin
                frame_d = frame_q + STAMP_W'(1);
              end
            end
            OP_INVALIDATE: begin
              valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (slot_id == id_q) begin
          // Hit: restamp the matching slot.
          wr_en        = 1'b1;
          wr_addr      = cmp_idx_q;
          valid_d[cmp_idx_q] = 1'b1;
          res_idx_d    = cmp_idx_q;
          res_status_d = ST_HIT;
          state_d      = S_RESP;
        end else if (cmp_idx_q == LAST_IDX) begin
          if (oldest_n == frame_q) begin
            res_idx_d    = '0;
            res_status_d = ST_FULL;
          end else begin
            // Load the id into the oldest slot.
            wr_en        = 1'b1;
            wr_addr      = victim_n;
            valid_d[victim_n] = 1'b1;
            res_idx_d    = victim_n;
            res_status_d = ST_LOAD;
          end
          state_d = S_RESP;
        end else begin
          oldest_d  = oldest_n;
          victim_d  = victim_n;
          cmp_idx_d = cmp_idx_q + IDX_W'(1);
          rd_en     = 1'b1;
          rd_addr   = cmp_idx_q + IDX_W'(1);
        end
      end

      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_idx_d    = res_idx_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= STAMP_W'(1);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    id_q         <= id_d;
    oldest_q     <= oldest_d;
    victim_q     <= victim_d;
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
  end

  // Output channel; slot numbers are cut to the four-bit field.
  assign slot_ext      = {{SLOT_W{1'b0}}, out_idx_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W){1'b0}}, slot_ext[SLOT_W-1:0]};
  assign m_axis_tuser  = out_status_q;

  `include "texture_unit_lru_binder_unit_macros.svh"

  `TULRU_ASSERT(a_wr_in_scan, !wr_en || (state_q == S_SCAN), "RAM write outside scan")
  `TULRU_ASSERT(a_hit_load_slot,
    !(out_valid_q && (out_status_q == ST_HIT || out_status_q == ST_LOAD)) || (out_idx_q != '0),
    "slot zero handed out")
  `TULRU_ASSERT_NEXT(a_frame_adv,
    in_fire && in_op == OP_ADVANCE && frame_q != FRAME_MAX,
    frame_q == $past(frame_q) + STAMP_W'(1), "frame counter did not advance")
  `TULRU_ASSERT(a_frame_nonzero, frame_q != '0, "frame counter wrapped to zero")

endmodule
`default_nettype wire
